[src/dpt_pkg.sv]
// Package for the demand paging translator: shared types, codes, constants.
// No dependencies.
package dpt_pkg;
  localparam int unsigned PROCESS_COUNT     = 4;
  localparam int unsigned FRAME_COUNT       = 8;
  localparam int unsigned PAGE_BYTES        = 4;
  localparam int unsigned PAGES_PER_PROCESS = 8;

  localparam logic KIND_ACCESS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_QUOTA  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [1:0] process_id;
    logic [4:0] virtual_address;
  } req_t;

  typedef struct packed {
    logic [4:0] physical_address;
    logic [2:0] frame_used;
    logic       page_fault;
    logic       evicted_valid;
    logic [2:0] evicted_page;
    logic       no_free_frame;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       release_step;
    logic       release_done;
    logic       hit_done;
    logic       take_free;
    logic       nofree_done;
    logic       lru_step;
    logic       fifo_pick;
    logic       scan_step;
    logic       evict_done;
  } dpt_cmd_t;

  typedef struct packed {
    logic kind;
    logic hit;
    logic may_take;
    logic queue_empty;
    logic release_last;
    logic lru_last;
    logic scan_last;
    logic out_busy;
  } dpt_sts_t;
endpackage

[src/dpt_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload type set by the instantiating code.
interface dpt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/dpt_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on nothing.
interface dpt_cfg_if ();
  logic       valid;
  logic       ready;
  logic       index;
  logic [3:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[src/dpt_ctrl.sv]
// Controller state machine for the demand paging translator.
// Depends on dpt_pkg.
module dpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dpt_pkg::dpt_sts_t sts_i,
  output dpt_pkg::dpt_cmd_t cmd_o
);
  import dpt_pkg::*;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_REL  = 3'd2;
  localparam logic [2:0] ST_LRU  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts_i.out_busy) begin
          state_d = ST_DEC;
        end else if (sts_i.kind == KIND_RELEASE) begin
          state_d = ST_REL;
        end else if (sts_i.hit) begin
          cmd_o.hit_done = 1'b1;
          state_d        = ST_IDLE;
        end else if (sts_i.may_take) begin
          if (sts_i.queue_empty) cmd_o.nofree_done = 1'b1;
          else cmd_o.take_free = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LRU;
        end
      end
      ST_REL: begin
        if (sts_i.release_last) begin
          cmd_o.release_done = 1'b1;
          state_d            = ST_IDLE;
        end else begin
          cmd_o.release_step = 1'b1;
        end
      end
      ST_LRU: begin
        if (sts_i.lru_last) begin
          cmd_o.fifo_pick = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          cmd_o.lru_step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.evict_done = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end
endmodule

[src/dpt_datapath.sv]
// Datapath: page tables, free queue, owned lists, use stamps, result register.
// Depends on dpt_pkg; driven by dpt_ctrl commands.
module dpt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpt_pkg::req_t     req_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [3:0]        cfg_wdata_i,
  input  dpt_pkg::dpt_cmd_t cmd_i,
  output dpt_pkg::dpt_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dpt_pkg::rsp_t     rsp_o
);
  import dpt_pkg::*;
  localparam int unsigned PW  = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int unsigned FW  = $clog2(FRAME_COUNT);
  localparam int unsigned CW  = $clog2(FRAME_COUNT + 1);
  localparam int unsigned GW  = $clog2(PAGES_PER_PROCESS);
  localparam int unsigned OW  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int unsigned TN  = PROCESS_COUNT * PAGES_PER_PROCESS;
  localparam int unsigned TW  = $clog2(TN);
  localparam int unsigned LN  = PROCESS_COUNT * FRAME_COUNT;
  localparam int unsigned LW  = $clog2(LN);

  logic             mode_q;
  logic [3:0]       quota_q;
  logic [FW-1:0]    pft_q [TN];
  logic [TN-1:0]    pvalid_q;
  logic [FW-1:0]    fq_q [FRAME_COUNT];
  logic [FW-1:0]    fhead_q;
  logic [CW-1:0]    fcnt_q;
  logic [FW-1:0]    own_q [LN];
  logic [CW-1:0]    ocnt_q [PROCESS_COUNT];
  logic [FW-1:0]    fptr_q [PROCESS_COUNT];
  logic [31:0]      stamp_q [FRAME_COUNT];
  logic [31:0]      clock_q;

  logic             kind_q;
  logic [PW-1:0]    pid_q;
  logic [GW-1:0]    page_q;
  logic [OW-1:0]    off_q;
  logic [CW-1:0]    idx_q;
  logic [CW-1:0]    best_q;
  logic [31:0]      best_stamp_q;
  logic [FW-1:0]    vframe_q;
  logic             ev_q;
  logic [GW-1:0]    evp_q;
  logic             out_valid_q;
  rsp_t             rsp_q;
  rsp_t             rsp_d;

  logic [TW-1:0]    tbase, tcur, tscan;
  logic [LW-1:0]    lbase, lcur;
  logic [CW-1:0]    ocnt, quota_eff;
  logic [FW-1:0]    lframe, hframe, slot;
  logic [FW-1:0]    ftail;

  assign tbase = TW'(pid_q) * TW'(PAGES_PER_PROCESS);
  assign tcur  = tbase + TW'(page_q);
  assign tscan = tbase + TW'(idx_q[GW-1:0]);
  assign lbase = LW'(pid_q) * LW'(FRAME_COUNT);
  assign lcur  = lbase + LW'(idx_q[FW-1:0]);
  assign ocnt  = ocnt_q[pid_q];
  assign lframe = own_q[lcur];
  assign hframe = pft_q[tcur];
  assign ftail  = fhead_q + fcnt_q[FW-1:0];

  always_comb begin
    quota_eff = (quota_q == 4'd0) ? CW'(1) : CW'(quota_q);
    if ({1'b0, quota_q} > 5'(FRAME_COUNT)) quota_eff = CW'(FRAME_COUNT);
  end

  // FIFO pointer stays below the owned count: it is cleared on release and the count only grows
  assign slot = mode_q ? best_q[FW-1:0] : fptr_q[pid_q];

  assign sts_o.kind         = kind_q;
  assign sts_o.hit          = pvalid_q[tcur];
  assign sts_o.may_take     = (ocnt < quota_eff) || (ocnt == '0);
  assign sts_o.queue_empty  = (fcnt_q == '0);
  assign sts_o.release_last = (idx_q >= ocnt);
  assign sts_o.lru_last     = !mode_q || (idx_q >= ocnt);
  assign sts_o.scan_last    = ev_q || (idx_q == CW'(PAGES_PER_PROCESS - 1));
  assign sts_o.out_busy     = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  function automatic logic [4:0] pa(input logic [FW-1:0] f, input logic [OW-1:0] o);
    return 5'({f, o});
  endfunction

  always_comb begin
    rsp_d = '0;
    if (cmd_i.hit_done) begin
      rsp_d.physical_address = pa(hframe, off_q);
      rsp_d.frame_used       = 3'(hframe);
    end
    if (cmd_i.take_free) begin
      rsp_d.physical_address = pa(fq_q[fhead_q], off_q);
      rsp_d.frame_used       = 3'(fq_q[fhead_q]);
      rsp_d.page_fault       = 1'b1;
    end
    if (cmd_i.nofree_done) rsp_d.no_free_frame = 1'b1;
    if (cmd_i.evict_done) begin
      rsp_d.physical_address = pa(vframe_q, off_q);
      rsp_d.frame_used       = 3'(vframe_q);
      rsp_d.page_fault       = 1'b1;
      rsp_d.evicted_valid    = ev_q;
      rsp_d.evicted_page     = 3'(evp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_i.kind;
      pid_q  <= PW'(req_i.process_id);
      page_q <= req_i.virtual_address[OW +: GW];
      off_q  <= req_i.virtual_address[OW-1:0];
    end
    if (cmd_i.take_free) begin
      own_q[lbase + LW'(ocnt)] <= fq_q[fhead_q];
      pft_q[tcur] <= fq_q[fhead_q];
    end
    if (cmd_i.evict_done) pft_q[tcur] <= vframe_q;
    if (cmd_i.fifo_pick) vframe_q <= own_q[lbase + LW'(slot)];
    if (cmd_i.hit_done || cmd_i.take_free || cmd_i.nofree_done || cmd_i.evict_done
        || cmd_i.release_done) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      quota_q      <= 4'd2;
      pvalid_q     <= '0;
      fhead_q      <= '0;
      fcnt_q       <= CW'(FRAME_COUNT);
      for (int i = 0; i < FRAME_COUNT; i++) begin
        fq_q[i]    <= FW'(i);
        stamp_q[i] <= '0;
      end
      for (int i = 0; i < PROCESS_COUNT; i++) begin
        ocnt_q[i] <= '0;
        fptr_q[i] <= '0;
      end
      clock_q      <= '0;
      idx_q        <= '0;
      best_q       <= '0;
      best_stamp_q <= '0;
      ev_q         <= 1'b0;
      evp_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_REPLACE_MODE) mode_q <= cfg_wdata_i[0];
        else quota_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.load) begin
        idx_q  <= '0;
        best_q <= '0;
        ev_q   <= 1'b0;
        evp_q  <= '0;
        if (req_i.kind == KIND_ACCESS) clock_q <= clock_q + 32'd1;
      end
      if (cmd_i.release_step) begin
        idx_q <= idx_q + CW'(1);
        if (fcnt_q < CW'(FRAME_COUNT)) begin
          fq_q[ftail] <= lframe;
          fcnt_q      <= fcnt_q + CW'(1);
        end
      end
      if (cmd_i.release_done) begin
        ocnt_q[pid_q] <= '0;
        fptr_q[pid_q] <= '0;
        for (int i = 0; i < PAGES_PER_PROCESS; i++) pvalid_q[tbase + TW'(i)] <= 1'b0;
        out_valid_q <= 1'b1;
      end
      if (cmd_i.hit_done) begin
        stamp_q[hframe] <= clock_q;
        out_valid_q     <= 1'b1;
      end
      if (cmd_i.nofree_done) out_valid_q <= 1'b1;
      if (cmd_i.take_free) begin
        stamp_q[fq_q[fhead_q]] <= clock_q;
        fhead_q  <= fhead_q + FW'(1);
        fcnt_q   <= fcnt_q - CW'(1);
        if (ocnt < CW'(FRAME_COUNT)) ocnt_q[pid_q] <= ocnt + CW'(1);
        pvalid_q[tcur] <= 1'b1;
        out_valid_q    <= 1'b1;
      end
      if (cmd_i.lru_step) begin
        if (idx_q == '0 || stamp_q[lframe] < best_stamp_q) begin
          best_q       <= idx_q;
          best_stamp_q <= stamp_q[lframe];
        end
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.fifo_pick) begin
        idx_q <= '0;
        if (!mode_q) begin
          fptr_q[pid_q] <= ((CW'(slot) + CW'(1)) == ocnt) ? '0 : slot + FW'(1);
        end
      end
      if (cmd_i.scan_step && !ev_q) begin
        if (pvalid_q[tscan] && pft_q[tscan] == vframe_q) begin
          ev_q  <= 1'b1;
          evp_q <= idx_q[GW-1:0];
          pvalid_q[tscan] <= 1'b0;
        end
        if (idx_q != CW'(PAGES_PER_PROCESS - 1)) idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.evict_done) begin
        stamp_q[vframe_q] <= clock_q;
        pvalid_q[tcur]    <= 1'b1;
        out_valid_q       <= 1'b1;
      end
    end
  end
endmodule

[src/demand_paging_translator.sv]
// Demand paging translator top level: controller plus datapath.
// Depends on dpt_pkg, dpt_if, dpt_cfg_if, dpt_ctrl, dpt_datapath.
// Result paths: hit, free-frame miss or empty queue are settled in the decode state; release
// steps through the frames owned; replacement searches the owned frames in LRU mode, then scans the pages.
// One item at a time; the next input transfer can share the edge of the result transfer.
// Reset is asynchronous: tables invalid, free queue holds every frame in order.
module demand_paging_translator (
  input logic    clk_i,
  input logic    rst_ni,
  dpt_if.sink    in_i,
  dpt_if.source  out_o,
  dpt_cfg_if.sink cfg_i
);
  import dpt_pkg::*;
  dpt_cmd_t cmd;
  dpt_sts_t sts;
  req_t     req;
  rsp_t     rsp;

  assign req         = in_i.data;
  assign out_o.data  = rsp;
  assign cfg_i.ready = 1'b1;

  dpt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpt_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i       (req),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_wdata_i (cfg_i.wdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .rsp_o       (rsp)
  );
endmodule

[bench/tb.sv]
// Self-checking bench for demand_paging_translator: directed and random accesses/releases,
// each result checked in order against an in-bench page-table predictor.
// Depends on dpt_pkg, dpt_if, dpt_cfg_if and the translator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 24;

  logic clk_i;
  logic rst_ni;
  int unsigned cycles;
  int unsigned mismatches;
  bit no_idle;

  dpt_if #(.T(req_t)) req_ch ();
  dpt_if #(.T(rsp_t)) rsp_ch ();
  dpt_cfg_if cfg_ch ();

  demand_paging_translator DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (rsp_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // predictor state
  bit [2:0]  frame_of[4][8];
  bit        mapped[4][8];
  bit [2:0]  free_frames[$];
  bit [2:0]  owned[4][$];
  int        fifo_ptr[4];
  bit [31:0] use_stamp[8];
  bit [31:0] use_count;
  bit        lru_mode;
  bit [3:0]  quota_reg;
  rsp_t      expected_rsp[$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic rsp_t translate(req_t r);
    rsp_t o;
    int p, pg, n, q, best;
    bit [2:0] fr;
    o = '0;
    p = int'(r.process_id);
    if (r.kind == KIND_RELEASE) begin
      foreach (owned[p][i]) if (free_frames.size() < 8) free_frames.push_back(owned[p][i]);
      owned[p].delete();
      fifo_ptr[p] = 0;
      for (int i = 0; i < 8; i++) mapped[p][i] = 1'b0;
      return o;
    end
    pg = int'(r.virtual_address[4:2]);
    use_count++;
    q = (quota_reg == 4'd0) ? 1 : (quota_reg > 4'd8 ? 8 : int'(quota_reg));
    n = owned[p].size();
    if (mapped[p][pg]) begin
      fr = frame_of[p][pg];
    end else if (n < q || n == 0) begin
      if (free_frames.size() == 0) begin
        o.no_free_frame = 1'b1;
        return o;
      end
      fr = free_frames.pop_front();
      if (n < 8) owned[p].push_back(fr);
      frame_of[p][pg] = fr;
      mapped[p][pg] = 1'b1;
      o.page_fault = 1'b1;
    end else begin
      best = 0;
      if (lru_mode) begin
        for (int i = 1; i < n; i++)
          if (use_stamp[owned[p][i]] < use_stamp[owned[p][best]]) best = i;
      end else begin
        best = fifo_ptr[p] % n;
        fifo_ptr[p] = (best + 1) % n;
      end
      fr = owned[p][best];
      for (int i = 0; i < 8; i++) begin
        if (mapped[p][i] && frame_of[p][i] == fr) begin
          o.evicted_valid = 1'b1;
          o.evicted_page = 3'(i);
          mapped[p][i] = 1'b0;
          break;
        end
      end
      frame_of[p][pg] = fr;
      mapped[p][pg] = 1'b1;
      o.page_fault = 1'b1;
    end
    use_stamp[fr] = use_count;
    o.frame_used = fr;
    o.physical_address = {fr, r.virtual_address[1:0]};
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(bit kind, bit [1:0] pid, bit [4:0] va);
    req_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    r.kind = kind;
    r.process_id = pid;
    r.virtual_address = va;
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    expected_rsp.push_back(translate(r));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(bit idx, bit [3:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_REPLACE_MODE) lru_mode = val[0];
    else quota_reg = val;
  endtask

  // sink side: random backpressure plus result check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) < 97 ? 1'b1 : 1'b0);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
        end else begin
          rsp_t e;
          e = expected_rsp.pop_front();
          if (rsp_ch.data !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, rsp_ch.data);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_fill_and_exhaust();
    write_reg(REG_FRAME_QUOTA, 4'd8);
    for (int i = 0; i < 8; i++) send_req(KIND_ACCESS, 2'd0, 5'(i * 4 + (i % 4)));
    send_req(KIND_ACCESS, 2'd0, 5'd31);
    send_req(KIND_ACCESS, 2'd3, 5'd0);
    send_req(KIND_ACCESS, 2'd0, 5'd0);
    send_req(KIND_RELEASE, 2'd0, 5'd31);
    send_req(KIND_ACCESS, 2'd3, 5'd17);
    send_req(KIND_RELEASE, 2'd3, 5'd0);
  endtask

  task automatic test_replacement();
    write_reg(REG_FRAME_QUOTA, 4'd2);
    write_reg(REG_REPLACE_MODE, 4'd0);
    send_req(KIND_ACCESS, 2'd1, 5'd0);
    send_req(KIND_ACCESS, 2'd1, 5'd4);
    send_req(KIND_ACCESS, 2'd1, 5'd8);
    send_req(KIND_ACCESS, 2'd1, 5'd12);
    write_reg(REG_REPLACE_MODE, 4'd1);
    send_req(KIND_ACCESS, 2'd1, 5'd8);
    send_req(KIND_ACCESS, 2'd1, 5'd16);
    write_reg(REG_FRAME_QUOTA, 4'd1);
    send_req(KIND_ACCESS, 2'd1, 5'd20);
    write_reg(REG_FRAME_QUOTA, 4'd0);
    send_req(KIND_ACCESS, 2'd2, 5'd3);
    send_req(KIND_ACCESS, 2'd2, 5'd7);
    send_req(KIND_RELEASE, 2'd1, 5'd0);
    send_req(KIND_RELEASE, 2'd2, 5'd0);
  endtask

  task automatic test_random();
    bit [3:0] quotas[6] = '{4'd2, 4'd1, 4'd8, 4'd15, 4'd0, 4'd3};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_REPLACE_MODE, 4'(ph % 2));
      write_reg(REG_FRAME_QUOTA, quotas[ph]);
      no_idle = (ph == 2);
      for (int i = 0; i < 230; i++) begin
        send_req($urandom_range(0, 99) < 8 ? KIND_RELEASE : KIND_ACCESS,
                 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    for (int i = 0; i < 8; i++) free_frames.push_back(3'(i));
    quota_reg = 4'd2;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_exhaust();
    test_replacement();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
